FILE: rtl/chunk_dedup_refcount_table_macros.svh
// assertion helpers for the dedup table
`ifndef CHUNK_DEDUP_REFCOUNT_TABLE_MACROS_SVH
`define CHUNK_DEDUP_REFCOUNT_TABLE_MACROS_SVH
// implication checked on every edge out of reset
`define CDRT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CDRT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/cdrt_pkg.sv
package cdrt_pkg;
  localparam int unsigned TableEntries = 64;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = 7;

  typedef enum logic [2:0] {
    OP_LOOKUP = 3'd0, OP_INSERT = 3'd1, OP_MARK = 3'd2, OP_INC = 3'd3,
    OP_DEC = 3'd4, OP_REMOVE = 3'd5, OP_PROBE = 3'd6, OP_NONE = 3'd7
  } op_t;

  localparam logic [1:0] RES_OK = 2'd0;
  localparam logic [1:0] RES_NOT_FOUND = 2'd1;
  localparam logic [1:0] RES_FULL = 2'd2;

  typedef struct packed {
    logic capture;  // latch input word and search table
    logic execute;  // apply operation and load result register
  } cmd_t;

  typedef struct packed {
    logic busy;
  } sts_t;
endpackage

FILE: rtl/cdrt_ctrl.sv
module cdrt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic          out_free,
  output cdrt_pkg::cmd_t cmd,
  output logic          in_ready
);
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_EXEC;
      ST_EXEC: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);
  assign cmd.capture = in_fire;
  assign cmd.execute = (state_r == ST_EXEC) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end
endmodule

FILE: rtl/cdrt_dp.sv
module cdrt_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  cdrt_pkg::cmd_t cmd,
  input  logic [2:0]     op_in,
  input  logic [63:0]    key_in,
  input  logic [31:0]    kv_in,
  input  logic [31:0]    meta_in,
  output logic [362:0]   res_word
);
  localparam int unsigned N = cdrt_pkg::TableEntries;
  localparam int unsigned IW = cdrt_pkg::IdxW;
  localparam int unsigned CW = cdrt_pkg::CntW;

  logic [N-1:0]  valid_r;
  logic [63:0]   key_mem [N];
  logic          done_mem [N];
  logic [31:0]   refs_mem [N];
  logic [31:0]   kv_mem [N];
  logic [31:0]   meta_mem [N];

  logic [2:0]    op_r;
  logic [63:0]   key_r;
  logic [31:0]   kv_r, meta_r;
  logic          hit_r, free_ok_r;
  logic [IW-1:0] hit_idx_r, free_idx_r;

  logic [63:0] hit_cnt_r, miss_cnt_r, saved_r, dbytes_r;
  logic [CW-1:0] dcnt_r;

  // search stage: lowest matching and lowest free slot
  logic          hit_c, free_c;
  logic [IW-1:0] hidx_c, fidx_c;
  always_comb begin
    hit_c = 1'b0; free_c = 1'b0; hidx_c = '0; fidx_c = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (valid_r[i] && key_mem[i] == key_in) begin
        hit_c = 1'b1; hidx_c = IW'(i);
      end
      if (!valid_r[i]) begin
        free_c = 1'b1; fidx_c = IW'(i);
      end
    end
  end

  // entry of the matching slot, read into registers with the search result
  logic        e_done_r;
  logic [31:0] e_refs_r, e_kv_r, e_meta_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= op_in; key_r <= key_in; kv_r <= kv_in; meta_r <= meta_in;
      hit_r <= hit_c; hit_idx_r <= hidx_c; free_ok_r <= free_c; free_idx_r <= fidx_c;
      e_done_r <= done_mem[hidx_c];
      e_refs_r <= refs_mem[hidx_c];
      e_kv_r   <= kv_mem[hidx_c];
      e_meta_r <= meta_mem[hidx_c];
    end
  end

  logic [31:0] refs_inc;
  assign refs_inc = (e_refs_r == 32'hFFFF_FFFF) ? e_refs_r : e_refs_r + 32'd1;

  logic [1:0]  rc;
  logic        ap, ec;
  logic [31:0] rv, rk, rm;
  always_comb begin
    rc = cdrt_pkg::RES_NOT_FOUND; ap = 1'b0; ec = 1'b0; rv = '0; rk = '0; rm = '0;
    if (hit_r) begin
      ec = e_done_r; rv = e_refs_r; rk = e_kv_r; rm = e_meta_r;
    end
    unique case (cdrt_pkg::op_t'(op_r))
      cdrt_pkg::OP_LOOKUP, cdrt_pkg::OP_REMOVE:
        if (hit_r) rc = cdrt_pkg::RES_OK;
      cdrt_pkg::OP_INSERT:
        if (hit_r) begin
          rc = cdrt_pkg::RES_OK;
          if (e_done_r) begin ap = 1'b1; rv = refs_inc; end
        end else if (free_ok_r) begin
          rc = cdrt_pkg::RES_OK; ec = 1'b0; rv = 32'd1; rk = kv_r; rm = meta_r;
        end else rc = cdrt_pkg::RES_FULL;
      cdrt_pkg::OP_MARK:
        if (hit_r) begin rc = cdrt_pkg::RES_OK; ec = 1'b1; end
      cdrt_pkg::OP_INC:
        if (hit_r) begin rc = cdrt_pkg::RES_OK; rv = refs_inc; end
      cdrt_pkg::OP_DEC:
        if (hit_r) begin
          rc = cdrt_pkg::RES_OK;
          rv = (e_refs_r == 32'd0) ? e_refs_r : e_refs_r - 32'd1;
        end
      cdrt_pkg::OP_PROBE:
        if (hit_r && e_done_r) begin rc = cdrt_pkg::RES_OK; ap = 1'b1; end
      default: rc = cdrt_pkg::RES_NOT_FOUND;
    endcase
    if (rc != cdrt_pkg::RES_OK) begin
      ap = 1'b0; ec = 1'b0; rv = '0; rk = '0; rm = '0;
    end
  end

  logic [63:0] hit_nxt, miss_nxt, saved_nxt, dbytes_nxt;
  logic [CW-1:0] dcnt_nxt;
  always_comb begin
    hit_nxt = hit_cnt_r; miss_nxt = miss_cnt_r; saved_nxt = saved_r;
    dbytes_nxt = dbytes_r; dcnt_nxt = dcnt_r;
    if (op_r == cdrt_pkg::OP_LOOKUP) begin
      if (hit_r) hit_nxt = hit_cnt_r + 64'd1;
      else miss_nxt = miss_cnt_r + 64'd1;
    end
    if (op_r == cdrt_pkg::OP_INSERT && hit_r && e_done_r)
      saved_nxt = saved_r + {32'd0, e_kv_r};
    if (op_r == cdrt_pkg::OP_MARK && hit_r && !e_done_r) begin
      dcnt_nxt = dcnt_r + CW'(1); dbytes_nxt = dbytes_r + {32'd0, e_kv_r};
    end
    if (op_r == cdrt_pkg::OP_REMOVE && hit_r && e_done_r) begin
      dcnt_nxt = dcnt_r - CW'(1); dbytes_nxt = dbytes_r - {32'd0, e_kv_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0; hit_cnt_r <= '0; miss_cnt_r <= '0; saved_r <= '0;
      dcnt_r <= '0; dbytes_r <= '0;
    end else if (cmd.execute) begin
      hit_cnt_r <= hit_nxt; miss_cnt_r <= miss_nxt; saved_r <= saved_nxt;
      dcnt_r <= dcnt_nxt; dbytes_r <= dbytes_nxt;
      if (op_r == cdrt_pkg::OP_INSERT && !hit_r && free_ok_r)
        valid_r[free_idx_r] <= 1'b1;
      if (op_r == cdrt_pkg::OP_REMOVE && hit_r)
        valid_r[hit_idx_r] <= 1'b0;
    end
  end

  // entry store
  always_ff @(posedge clk) begin
    if (cmd.execute && hit_r) begin
      if ((op_r == cdrt_pkg::OP_INSERT && e_done_r) || op_r == cdrt_pkg::OP_INC ||
          op_r == cdrt_pkg::OP_DEC)
        refs_mem[hit_idx_r] <= rv;
      if (op_r == cdrt_pkg::OP_MARK) done_mem[hit_idx_r] <= 1'b1;
    end else if (cmd.execute && op_r == cdrt_pkg::OP_INSERT && free_ok_r) begin
      key_mem[free_idx_r] <= key_r;
      done_mem[free_idx_r] <= 1'b0;
      refs_mem[free_idx_r] <= 32'd1;
      kv_mem[free_idx_r] <= kv_r;
      meta_mem[free_idx_r] <= meta_r;
    end
  end

  assign res_word = {dbytes_nxt, dcnt_nxt, saved_nxt, miss_nxt, hit_nxt,
                     rm, rk, rv, ec, ap, rc};
endmodule

FILE: rtl/chunk_dedup_refcount_table.sv
// search and entry read are registered at the accepting edge; read-modify-write then
// loads the output register, and no new word is taken until it has done so
// a result word still held in the output register delays the update cycle and the input
// the parallel key compare over all 64 slots sets the search cycle
// reset: rst_n synchronous, clears valid bits, counters and handshake state
// slot contents are not cleared; no clearing pass is needed
`include "chunk_dedup_refcount_table_macros.svh"
module chunk_dedup_refcount_table (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode[2:0], chunk_key[66:3], data_size[98:67], meta_blob_size[130:99]
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_code[1:0], already_present[2], entry_complete[3], ref_value[35:4],
  // entry_kv_size[67:36], entry_meta_size[99:68], hit_total[163:100],
  // miss_total[227:164], saved_bytes_total[291:228], complete_chunks[298:292],
  // complete_bytes[362:299]
  output logic [367:0] out_tdata
);
  cdrt_pkg::cmd_t cmd;
  logic           in_fire, out_free, rdy;
  logic [362:0]   res_w;
  logic           out_valid_r;
  logic [367:0]   out_data_r;

  assign in_fire  = in_tvalid && in_tready;
  // output register free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = rdy;

  cdrt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
    .cmd(cmd), .in_ready(rdy)
  );

  // datapath word: rc/ap/ec/refs/kv/meta then counters, already in port order
  cdrt_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .op_in(in_tdata[2:0]), .key_in(in_tdata[66:3]),
    .kv_in(in_tdata[98:67]), .meta_in(in_tdata[130:99]),
    .res_word(res_w)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.execute) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) out_data_r <= {5'd0, res_w};
  end

  `CDRT_ASSERT_NXT(a_in_blocks, in_fire, !in_tready, "second word taken during execute")
  `CDRT_ASSERT_IMP(a_exec_free, cmd.execute, out_free, "result overwrote pending word")
  `CDRT_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "held word changed")
endmodule
